/* rtl/lequf_pkg.sv */
// shared types, constants and helper functions for the letter equivalence store
package lequf_pkg;

    // alphabet and field widths
    localparam int ALPHABET_SIZE = 26;
    localparam int LETTER_W      = 5;
    localparam int OPCODE_W      = 2;
    localparam int IDX_W         = $clog2(ALPHABET_SIZE);
    localparam int SIZE_W        = $clog2(ALPHABET_SIZE + 1);
    localparam int EXT_W         = LETTER_W + IDX_W + 1;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [SIZE_W-1:0]   t_size;

    // operation codes carried by the opcode field
    typedef enum logic [OPCODE_W-1:0] {
        OP_JOIN  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK_X,
        ST_WALK_Y,
        ST_LINK,
        ST_WALK_Q,
        ST_RESULT
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic in_ready;
        logic node_from_x;
        logic node_from_y;
        logic walk_step;
        logic capture_x;
        logic capture_y;
        logic link;
        logic clear_all;
        logic load_out;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic                accepted;
        logic [OPCODE_W-1:0] op;
        logic                x_in_range;
        logic                y_in_range;
        logic                node_is_root;
        logic                out_free;
    } t_dp_status;

    // letter code to array index
    function automatic t_idx to_index(input t_letter l);
        logic [EXT_W-1:0] wide;
        wide = {{(IDX_W + 1){1'b0}}, l};
        return wide[IDX_W-1:0];
    endfunction

    // array index to letter code, masked to the letter width
    function automatic t_letter to_letter(input t_idx i);
        logic [EXT_W-1:0] wide;
        wide = {{(LETTER_W + 1){1'b0}}, i};
        return wide[LETTER_W-1:0];
    endfunction

    // letter lies inside the alphabet
    function automatic logic in_alphabet(input t_letter l);
        logic [EXT_W-1:0] wide;
        wide = {{(IDX_W + 1){1'b0}}, l};
        return wide < EXT_W'(ALPHABET_SIZE);
    endfunction

endpackage

/* rtl/lequf_if.sv */
// handshake channels for input items and result items

// input item channel
interface lequf_item_if;
    logic                          valid;
    logic                          ready;
    logic [lequf_pkg::OPCODE_W-1:0] opcode;
    logic [lequf_pkg::LETTER_W-1:0] first_letter;
    logic [lequf_pkg::LETTER_W-1:0] second_letter;

    modport source (output valid, output opcode, output first_letter,
                    output second_letter, input ready);
    modport sink   (input valid, input opcode, input first_letter,
                    input second_letter, output ready);
endinterface

// result item channel
interface lequf_result_if;
    logic                          valid;
    logic                          ready;
    logic [lequf_pkg::LETTER_W-1:0] smallest_equivalent;

    modport source (output valid, output smallest_equivalent, input ready);
    modport sink   (input valid, input smallest_equivalent, output ready);
endinterface

/* rtl/letter_equivalence_union_find.sv */
// top level of the letter equivalence store: disjoint sets joined by size
// Usage:
//   i_item carries one transaction per item: opcode join, query or clear,
//   first_letter and second_letter (0 stands for a). o_result carries one
//   transaction per query: the smallest letter in the queried letter's class.
//   Join and clear give no result; unused opcodes are dropped.
// Timing:
//   The block takes one item at a time; i_item.ready is high only when idle.
//   A join walks the parent links from each of its letters to the class root,
//   a query from its letter; a walk is at most 4 links long with 26 letters.
//   The walks are set by the single read port of the class tables, one link
//   per cycle.
// Reset:
//   Every letter is its own class right after reset; reset and clear drop
//   all valid bits at once, no sweep of the tables.
// Stall:
//   A result stays in the output register until taken. The next item is
//   accepted meanwhile; a later query waits at its end for the register.
module letter_equivalence_union_find (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lequf_item_if.sink     i_item,
    lequf_result_if.source o_result
);
    import lequf_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer
    lequf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // tables and registers
    lequf_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

endmodule

/* rtl/lequf_ctrl.sv */
// sequencer for decode, root walks, linking and result hand-off
module lequf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lequf_pkg::t_dp_status i_status,
    output lequf_pkg::t_dp_cmd    o_cmd
);
    import lequf_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.accepted) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_status.op)
                    OP_JOIN: begin
                        if (i_status.x_in_range && i_status.y_in_range) begin
                            o_cmd.node_from_x = 1'b1;
                            n_state = ST_WALK_X;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                    OP_QUERY: begin
                        if (i_status.x_in_range) begin
                            o_cmd.node_from_x = 1'b1;
                            n_state = ST_WALK_Q;
                        end else begin
                            n_state = ST_RESULT;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clear_all = 1'b1;
                        n_state = ST_IDLE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_WALK_X: begin
                if (i_status.node_is_root) begin
                    o_cmd.capture_x   = 1'b1;
                    o_cmd.node_from_y = 1'b1;
                    n_state = ST_WALK_Y;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            ST_WALK_Y: begin
                if (i_status.node_is_root) begin
                    o_cmd.capture_y = 1'b1;
                    n_state = ST_LINK;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            ST_LINK: begin
                o_cmd.link = 1'b1;
                n_state = ST_IDLE;
            end
            ST_WALK_Q: begin
                if (i_status.node_is_root) begin
                    o_cmd.capture_x = 1'b1;
                    n_state = ST_RESULT;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            ST_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/lequf_dp.sv */
// datapath: item capture, class tables, walk pointer and result register
module lequf_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lequf_item_if.sink            i_item,
    lequf_result_if.source        o_result,
    input  lequf_pkg::t_dp_cmd    i_cmd,
    output lequf_pkg::t_dp_status o_status
);
    import lequf_pkg::*;

    // class tables; an entry without its valid bit reads as its reset value
    t_idx  r_parent [ALPHABET_SIZE];
    logic  r_is_root [ALPHABET_SIZE];
    t_size r_size [ALPHABET_SIZE];
    t_idx  r_min [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_valid;

    // captured item and walk registers
    logic [OPCODE_W-1:0] r_op;
    t_letter r_x;
    t_letter r_y;
    t_idx    r_node;
    t_idx    r_root_x;
    t_size   r_size_x;
    t_idx    r_min_x;
    t_idx    r_root_y;
    t_size   r_size_y;
    t_idx    r_min_y;

    // result register
    logic    r_out_valid;
    t_letter r_out_data;

    logic  accepted;
    logic  rd_root;
    t_idx  rd_parent;
    t_size rd_size;
    t_idx  rd_min;
    logic  x_under_y;
    t_idx  child;
    t_idx  top;
    t_size child_size;
    t_idx  child_min;
    logic [SIZE_W:0] size_sum;
    t_idx  joined_min;
    logic [ALPHABET_SIZE-1:0] valid_set;

    assign accepted       = i_item.valid && i_cmd.in_ready;
    assign i_item.ready   = i_cmd.in_ready;
    assign o_result.valid = r_out_valid;
    assign o_result.smallest_equivalent = r_out_data;

    // table read at the walk pointer
    always_comb begin
        if (r_valid[r_node]) begin
            rd_root   = r_is_root[r_node];
            rd_parent = r_parent[r_node];
            rd_size   = r_size[r_node];
            rd_min    = r_min[r_node];
        end else begin
            rd_root   = 1'b1;
            rd_parent = r_node;
            rd_size   = t_size'(1);
            rd_min    = r_node;
        end
    end

    // union by size, second root under first on a tie
    always_comb begin
        x_under_y  = r_size_x < r_size_y;
        child      = x_under_y ? r_root_x : r_root_y;
        top        = x_under_y ? r_root_y : r_root_x;
        child_size = x_under_y ? r_size_x : r_size_y;
        child_min  = x_under_y ? r_min_x : r_min_y;
        size_sum   = {1'b0, r_size_x} + {1'b0, r_size_y};
        joined_min = (r_min_x < r_min_y) ? r_min_x : r_min_y;
    end

    // entries that become valid on a link
    always_comb begin
        valid_set        = '0;
        valid_set[child] = 1'b1;
        valid_set[top]   = 1'b1;
    end

    // status toward the controller
    always_comb begin
        o_status.accepted     = accepted;
        o_status.op           = r_op;
        o_status.x_in_range   = in_alphabet(r_x);
        o_status.y_in_range   = in_alphabet(r_y);
        o_status.node_is_root = rd_root;
        o_status.out_free     = !r_out_valid || o_result.ready;
    end

    // item capture and walk registers
    always_ff @(posedge i_clk) begin
        if (accepted) begin
            r_op <= i_item.opcode;
            r_x  <= i_item.first_letter;
            r_y  <= i_item.second_letter;
        end
        if (i_cmd.node_from_x) begin
            r_node <= to_index(r_x);
        end else if (i_cmd.node_from_y) begin
            r_node <= to_index(r_y);
        end else if (i_cmd.walk_step) begin
            r_node <= rd_parent;
        end
        if (i_cmd.capture_x) begin
            r_root_x <= r_node;
            r_size_x <= rd_size;
            r_min_x  <= rd_min;
        end
        if (i_cmd.capture_y) begin
            r_root_y <= r_node;
            r_size_y <= rd_size;
            r_min_y  <= rd_min;
        end
    end

    // table contents: the child entry and the new root entry on a link
    always_ff @(posedge i_clk) begin
        if (i_cmd.link && (r_root_x != r_root_y)) begin
            r_parent[child]  <= top;
            r_is_root[child] <= 1'b0;
            r_size[child]    <= child_size;
            r_min[child]     <= child_min;
            r_parent[top]    <= top;
            r_is_root[top]   <= 1'b1;
            r_size[top]      <= size_sum[SIZE_W-1:0];
            r_min[top]       <= joined_min;
        end
    end

    // valid bits, cleared at once by reset or a clear transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.clear_all) begin
            r_valid <= '0;
        end else if (i_cmd.link && (r_root_x != r_root_y)) begin
            r_valid <= r_valid | valid_set;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.load_out || (r_out_valid && !o_result.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= in_alphabet(r_x) ? to_letter(r_min_x) : r_x;
        end
    end

endmodule

/* rtl/lequf_checker.sv */
// port checker for the letter equivalence store, bound to the top level
module lequf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic [lequf_pkg::LETTER_W-1:0] i_out_data
);
    import lequf_pkg::*;

    // one item at a time: busy right after an accepted transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready high right after an accepted transaction");

    // a new result is loaded only while no item can be taken
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while input was ready");

    // reset empties the result register
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result holds its value
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result dropped or changed");

endmodule

bind letter_equivalence_union_find lequf_checker u_lequf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.smallest_equivalent)
);
